[hdl/sobel_edge_magnitude_rgb_assert.svh]
// Assertion macros shared by the Sobel edge block checkers.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SEM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sobel edge check failed");

// Next-cycle implication.
`define SEM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sobel edge check failed");

`endif

[hdl/sem_pkg.sv]
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

	localparam int SEM_MAX_WIDTH = 1024;
	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int GRAD_W = 11;
	localparam int SUM_W  = 21;
	localparam int FW_W   = 11;
	localparam int FH_W   = 12;
	localparam int ROW_W  = 13;
	localparam int CFG_W  = 12;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RESET = 12'd480;

	typedef struct packed {
		logic       start;
		logic       mem;
		logic       grad;
		logic       load_root;
		logic       step;
		logic [2:0] bit_idx;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic emit;
		logic out_free;
	} stat_t;

endpackage

[hdl/sem_root.sv]
// Squared magnitude and bit-serial rounded square root for one channel.
module sem_root (
	input  logic                             clk,
	input  logic                             load,
	input  logic                             step,
	input  logic [2:0]                       bit_idx,
	input  logic signed [sem_pkg::GRAD_W-1:0] gx,
	input  logic signed [sem_pkg::GRAD_W-1:0] gy,
	output logic [sem_pkg::CH_W-1:0]          mag
);
	import sem_pkg::*;

	logic signed [2*GRAD_W-1:0] sq_x, sq_y, sq_sum;
	logic [SUM_W-1:0]           s_q;
	logic [CH_W-1:0]            n_q;
	logic [CH_W-1:0]            trial;
	logic [2*CH_W-1:0]          trial_sq;
	logic [2*CH_W:0]            n_sq_n;
	logic [CH_W:0]              n_up;

	assign sq_x   = gx * gx;
	assign sq_y   = gy * gy;
	assign sq_sum = sq_x + sq_y;

	assign trial    = n_q | (CH_W'(1) << bit_idx);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk) begin
		if (load) begin
			s_q <= sq_sum[SUM_W-1:0];
			n_q <= '0;
		end else if (step) begin
			if (SUM_W'(trial_sq) <= s_q) begin
				n_q <= trial;
			end
		end
	end

	// round up when s > n*n + n; anything past 255.5^2 clamps
	assign n_sq_n = (2*CH_W+1)'(n_q * n_q) + (2*CH_W+1)'(n_q);
	assign n_up   = (SUM_W'(n_sq_n) < s_q) ? ((CH_W+1)'(n_q) + 1'b1) : (CH_W+1)'(n_q);

	always_comb begin
		if (s_q > SUM_W'(65280) || n_up[CH_W]) begin
			mag = '1;
		end else begin
			mag = n_up[CH_W-1:0];
		end
	end

endmodule

[hdl/sem_ctrl.sv]
// Sequencer of the Sobel edge block: steps one item through the datapath.
module sem_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  sem_pkg::stat_t stat,
	output sem_pkg::cmd_t  cmd
);
	import sem_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEM,
		ST_GRAD,
		ST_SQR,
		ST_ROOT,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;

	assign s_tready      = (state_q == ST_IDLE);
	assign cmd.start     = s_tvalid && s_tready && !stat.skip;
	assign cmd.mem       = (state_q == ST_MEM);
	assign cmd.grad      = (state_q == ST_GRAD);
	assign cmd.load_root = (state_q == ST_SQR);
	assign cmd.step      = (state_q == ST_ROOT);
	assign cmd.bit_idx   = cnt_q;
	assign cmd.load_out  = (state_q == ST_OUT) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					state_q <= stat.emit ? ST_GRAD : ST_IDLE;
				end
				ST_GRAD: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_ROOT;
					cnt_q   <= 3'd7;
				end
				ST_ROOT: begin
					if (cnt_q == 3'd0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				ST_OUT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/sem_datapath.sv]
// Line buffers, window, counters, gradients and output register.
module sem_datapath #(
	parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
	input  logic [sem_pkg::PIX_W-1:0]   s_tdata,
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sem_pkg::PIX_W-1:0]   m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser,
	input  sem_pkg::cmd_t               cmd,
	output sem_pkg::stat_t              stat
);
	import sem_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [FW_W-1:0]  eff_w;
	logic [FH_W-1:0]  eff_h;

	logic [COL_W-1:0] in_col_q, out_col_q, col_s1;
	logic [ROW_W-1:0] in_row_q;
	logic [FH_W-1:0]  out_row_q;

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] top_s1, mid_s1, pix_s1;
	logic             emit_s1;

	logic [PIX_W-1:0] win_q  [3][3];
	logic [PIX_W-1:0] newcol [3];
	logic [PIX_W-1:0] nb_d   [3][3];
	logic [PIX_W-1:0] nb_s2  [3][3];
	logic             row_end_d, frame_end_d, row_end_s2, frame_end_s2;

	logic [CH_W-1:0]          mag   [3];

	logic in_frame, in_col_last, restart, cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			eff_w = FW_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = FW_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == '0) ? FH_W'(1) : height_q;
	end

	assign in_frame    = in_row_q < ROW_W'(eff_h);
	assign in_col_last = (ROW_W'(in_col_q) + 1'b1) >= ROW_W'(eff_w);
	assign cfg_hit     = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	assign stat.skip     = in_frame && s_tuser;
	assign stat.emit     = emit_s1;
	assign stat.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// line buffers: read on accept (not for a pad inside the frame), write back the cycle after
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			top_s1 <= upper_mem[in_col_q];
			mid_s1 <= middle_mem[in_col_q];
			pix_s1 <= in_frame ? s_tdata : '0;
			col_s1 <= in_col_q;
		end
		if (cmd.mem) begin
			upper_mem[col_s1]  <= mid_s1;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	always_comb begin
		newcol[0] = top_s1;
		newcol[1] = mid_s1;
		newcol[2] = pix_s1;
		row_end_d   = (ROW_W'(out_col_q) + 1'b1) >= ROW_W'(eff_w);
		frame_end_d = row_end_d && ((ROW_W'(out_row_q) + 1'b1) >= ROW_W'(eff_h));
		for (int r = 0; r < 3; r++) begin
			nb_d[r][0] = (out_col_q == '0) ? '0 : win_q[r][1];
			nb_d[r][1] = win_q[r][2];
			nb_d[r][2] = (col_s1 == '0 || row_end_d) ? '0 : newcol[r];
		end
		if (out_row_q == '0) begin
			for (int k = 0; k < 3; k++) nb_d[0][k] = '0;
		end
		if ((ROW_W'(out_row_q) + 1'b1) >= ROW_W'(eff_h)) begin
			for (int k = 0; k < 3; k++) nb_d[2][k] = '0;
		end
	end

	assign restart = cmd.mem && emit_s1 && frame_end_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			emit_s1   <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
			end
		end else if (cfg_hit || restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
			end
		end else begin
			if (cmd.start) begin
				emit_s1 <= (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
				if (in_col_last) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.mem) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
					win_q[r][2] <= newcol[r];
				end
				if (emit_s1) begin
					if (row_end_d) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem) begin
			nb_s2        <= nb_d;
			row_end_s2   <= row_end_d;
			frame_end_s2 <= frame_end_d;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic signed [GRAD_W-1:0] v [3][3];
		logic signed [GRAD_W-1:0] gx_d, gy_d;
		logic signed [GRAD_W-1:0] gx_s3, gy_s3;

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					v[r][k] = signed'({3'b000, nb_s2[r][k][CH_W*ch +: CH_W]});
				end
			end
			gx_d = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
			gy_d = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
		end

		always_ff @(posedge clk) begin
			if (cmd.grad) begin
				gx_s3 <= gx_d;
				gy_s3 <= gy_d;
			end
		end

		sem_root u_root (
			.clk     (clk),
			.load    (cmd.load_root),
			.step    (cmd.step),
			.bit_idx (cmd.bit_idx),
			.gx      (gx_s3),
			.gy      (gy_s3),
			.mag     (mag[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= {mag[2], mag[1], mag[0]};
			m_tlast <= frame_end_s2;
			m_tuser <= row_end_s2;
		end
	end

endmodule

[hdl/sobel_edge_magnitude_rgb.sv]
// An input with a result passes buffer access, gradient, square, the 8-step root loop and
// output, where it waits for a free output register, before a new input is taken; one
// without a result returns to idle after buffer access, and a pad inside the frame is taken in idle.
// Output register lets the next input transfer while a result waits downstream.
// Reset (arst_n low, async): width 640, height 480, counters and window cleared.
// Line buffers hold no reset; entries are read only after being written or where masked.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration writes: index 0 frame_width, index 1 frame_height
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data,
	// input pixels
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [sem_pkg::PIX_W-1:0] s_tdata,   // red_in, green_in, blue_in
	input  logic                      s_tuser,   // op: 1 = pad
	// edge magnitudes
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [sem_pkg::PIX_W-1:0] m_tdata,   // red_edge, green_edge, blue_edge
	output logic                      m_tlast,   // frame_end
	output logic                      m_tuser    // row_end
);
	import sem_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: idle -> buffer access -> gradient -> square -> 8 root steps -> output
	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// line buffers, 3x3 window with border masking, three channel root units
	sem_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

[hdl/sem_checker.sv]
// Port-level checks of the Sobel edge block and their bind.
`include "sobel_edge_magnitude_rgb_assert.svh"

module sem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	`SEM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`SEM_ASSERT_NOW(a_frame_end_row_end, m_tvalid && m_tlast, m_tuser)
	`SEM_ASSERT_NEXT(a_pixel_busy, s_tvalid && s_tready && !s_tuser, !s_tready)
	`SEM_ASSERT_NOW(a_result_after_busy, $rose(m_tvalid), !$past(s_tready))

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
